@@ sv/aad_pkg.sv @@
// Package for the audio artifact detector: widths, register codes, reset values, shared types.
package aad_pkg;

  localparam int SAMPLE_BITS         = 24;
  localparam int MAX_CHANNEL_SAMPLES = 16777216;
  localparam int CNT_W               = 25;
  localparam int SUM_W               = 48;
  localparam int TOT_W               = 32;
  localparam int LVL_W               = 24;
  localparam int LEN_W               = 16;
  localparam int MAG_W               = 24;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_DATA_W          = 24;
  localparam int RATIO_W             = 14;
  localparam int OUT_DATA_W          = 176;

  localparam logic [RATIO_W-1:0] CLIP_RATIO = RATIO_W'(10000);

  localparam logic [LVL_W-1:0] CLIP_LEVEL_RST     = LVL_W'(8384414);
  localparam logic [LVL_W-1:0] CLICK_STEP_RST     = LVL_W'(4194304);
  localparam logic [LEN_W-1:0] CLICK_HOLD_RST     = LEN_W'(200);
  localparam logic [LVL_W-1:0] SILENCE_LEVEL_RST  = LVL_W'(84);
  localparam logic [LEN_W-1:0] DROPOUT_LENGTH_RST = LEN_W'(960);

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CLIP_LEVEL     = 3'd0,
    CFG_CLICK_STEP     = 3'd1,
    CFG_CLICK_HOLD     = 3'd2,
    CFG_SILENCE_LEVEL  = 3'd3,
    CFG_DROPOUT_LENGTH = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0] clip_level;
    logic [LVL_W-1:0] click_step;
    logic [LEN_W-1:0] click_hold;
    logic [LVL_W-1:0] silence_level;
    logic [LEN_W-1:0] dropout_length;
  } cfg_t;

  typedef struct packed {
    logic [TOT_W-1:0] clips;
    logic [TOT_W-1:0] samples;
    logic [TOT_W-1:0] clicks;
    logic [TOT_W-1:0] dropouts;
    logic [MAG_W-1:0] peak;
  } totals_t;

endpackage

@@ sv/audio_artifact_detector.sv @@
// Top level of the audio artifact detector: config registers, sequencer, result register.
//
// Samples enter on the in_ stream, channel after channel; in_tlast marks the last
// sample of a channel, in_tuser carries the first-of-channel and end-of-buffer flags.
// Each sample is checked in the cycle it is accepted, so samples inside a channel
// go in at one per cycle. On the last sample of a channel the block drops in_tready
// and computes the channel's absolute mean with a shared restoring divider, one
// quotient bit per cycle, passing through a setup state, the divide state and a load
// of the output register; in_tready stays low until that load. The result waits in
// the output register, and the block takes further samples while it waits. A new
// channel end that finds the register still full holds in the divide state until
// out_tready frees it.
// Configuration writes on cfg_ are always taken (cfg_ready is high) and should only
// be issued while the block is idle; unknown indexes are ignored.
// Reset (rst_n low, synchronous) restores the default thresholds, clears all counts
// and the open channel, and empties the output register.
module audio_artifact_detector (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [aad_pkg::SAMPLE_BITS-1:0]    in_tdata,   // [23:0] sample
  input  logic [1:0]                         in_tuser,   // [0] channel_first, [1] buffer_last
  input  logic                               in_tlast,   // channel_last
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [23:0] channel_abs_mean, [55:24] clip_total, [87:56] sample_total,
  // [119:88] click_total, [151:120] dropout_total, [175:152] peak_magnitude
  output logic [aad_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser,  // clipping_flag
  output logic                               out_tlast,  // final_channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aad_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [aad_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV
  } state_t;

  localparam int PROD_W = aad_pkg::TOT_W + aad_pkg::RATIO_W;
  localparam logic [PROD_W-1:0] CLIP_RATIO_EXT = PROD_W'(aad_pkg::CLIP_RATIO);

  state_t                          state_r, state_nxt;
  aad_pkg::cfg_t                   cfg_r, cfg_nxt;
  logic                            final_r, final_nxt;
  aad_pkg::totals_t                snap_r, snap_nxt;
  logic [PROD_W-1:0]               prod_r, prod_nxt;
  logic                            zero_r, zero_nxt;
  logic                            ovalid_r, ovalid_nxt;
  logic [aad_pkg::OUT_DATA_W-1:0]  odata_r, odata_nxt;
  logic                            ouser_r, ouser_nxt;
  logic                            olast_r, olast_nxt;

  logic                            accept;
  logic                            clr_buf;
  logic                            div_start, div_busy;
  logic [aad_pkg::SUM_W-1:0]       dividend;
  logic [aad_pkg::MAG_W-1:0]       quotient, mean;
  logic [aad_pkg::CNT_W-2:0]       half;
  aad_pkg::totals_t                tot;
  logic signed [aad_pkg::SUM_W-1:0] chan_sum;
  logic [aad_pkg::CNT_W-1:0]       chan_cnt;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign clr_buf   = (state_r == ST_PREP) && final_r;
  assign div_start = (state_r == ST_PREP);
  assign half      = chan_cnt[aad_pkg::CNT_W-1:1];
  assign dividend  = chan_sum[aad_pkg::SUM_W-1]
                   ? aad_pkg::SUM_W'(half) - chan_sum
                   : chan_sum + aad_pkg::SUM_W'(half);
  assign mean      = zero_r ? '0 : quotient;

  aad_sample_unit u_sample (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .en       (accept),
    .sample   (in_tdata),
    .first    (in_tuser[0]),
    .last     (in_tlast),
    .clr_buf  (clr_buf),
    .tot      (tot),
    .chan_sum (chan_sum),
    .chan_cnt (chan_cnt)
  );

  aad_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (chan_cnt),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        aad_pkg::CFG_CLIP_LEVEL:     cfg_nxt.clip_level     = cfg_data;
        aad_pkg::CFG_CLICK_STEP:     cfg_nxt.click_step     = cfg_data;
        aad_pkg::CFG_CLICK_HOLD:     cfg_nxt.click_hold     = cfg_data[aad_pkg::LEN_W-1:0];
        aad_pkg::CFG_SILENCE_LEVEL:  cfg_nxt.silence_level  = cfg_data;
        aad_pkg::CFG_DROPOUT_LENGTH: cfg_nxt.dropout_length = cfg_data[aad_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt  = state_r;
    final_nxt  = final_r;
    snap_nxt   = snap_r;
    prod_nxt   = prod_r;
    zero_nxt   = zero_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_tlast) begin
          final_nxt = in_tuser[1];
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        snap_nxt  = tot;
        prod_nxt  = tot.clips * CLIP_RATIO_EXT;
        zero_nxt  = (chan_cnt == '0);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && (!ovalid_r || out_tready)) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {snap_r.peak, snap_r.dropouts, snap_r.clicks,
                        snap_r.samples, snap_r.clips, mean};
          ouser_nxt  = (prod_r > PROD_W'(snap_r.samples));
          olast_nxt  = final_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cfg_r    <= '{clip_level:     aad_pkg::CLIP_LEVEL_RST,
                    click_step:     aad_pkg::CLICK_STEP_RST,
                    click_hold:     aad_pkg::CLICK_HOLD_RST,
                    silence_level:  aad_pkg::SILENCE_LEVEL_RST,
                    dropout_length: aad_pkg::DROPOUT_LENGTH_RST};
      final_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cfg_r    <= cfg_nxt;
      final_r  <= final_nxt;
      ovalid_r <= ovalid_nxt;
    end
    snap_r  <= snap_nxt;
    prod_r  <= prod_nxt;
    zero_r  <= zero_nxt;
    odata_r <= odata_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

endmodule

@@ sv/aad_sample_unit.sv @@
// Per-sample checks: clip, dropout, click and peak counters plus the channel sum and count.
module aad_sample_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aad_pkg::cfg_t                       cfg,
  input  logic                                en,
  input  logic signed [aad_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                first,
  input  logic                                last,
  input  logic                                clr_buf,
  output aad_pkg::totals_t                    tot,
  output logic signed [aad_pkg::SUM_W-1:0]    chan_sum,
  output logic [aad_pkg::CNT_W-1:0]           chan_cnt
);

  localparam int SB = aad_pkg::SAMPLE_BITS;

  logic signed [SB-1:0]             prev_r, prev_nxt;
  logic                             have_r, have_nxt;
  logic                             open_r, open_nxt;
  logic [aad_pkg::LEN_W-1:0]        hold_r, hold_nxt;
  logic [aad_pkg::LEN_W-1:0]        run_r, run_nxt;
  logic signed [aad_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [aad_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  aad_pkg::totals_t                 tot_r, tot_nxt;

  logic                             start;
  logic [aad_pkg::MAG_W-1:0]        mag_cur, mag_prev, top;
  logic signed [SB:0]               step;
  logic [SB:0]                      step_mag;
  logic [aad_pkg::LEN_W-1:0]        hold_cur, run_cur;
  logic                             have_cur;

  assign start    = first || !open_r;
  assign mag_cur  = sample[SB-1] ? aad_pkg::MAG_W'(-sample) : aad_pkg::MAG_W'(sample);
  assign mag_prev = prev_r[SB-1] ? aad_pkg::MAG_W'(-prev_r) : aad_pkg::MAG_W'(prev_r);
  assign top      = (mag_prev > mag_cur) ? mag_prev : mag_cur;
  assign step     = {sample[SB-1], sample} - {prev_r[SB-1], prev_r};
  assign step_mag = step[SB] ? (SB+1)'(-step) : (SB+1)'(step);
  assign hold_cur = start ? '0 : hold_r;
  assign run_cur  = start ? '0 : run_r;
  assign have_cur = start ? 1'b0 : have_r;

  always_comb begin
    prev_nxt = prev_r;
    have_nxt = have_r;
    open_nxt = open_r;
    hold_nxt = hold_r;
    run_nxt  = run_r;
    sum_nxt  = sum_r;
    cnt_nxt  = cnt_r;
    tot_nxt  = tot_r;
    if (en) begin
      sum_nxt  = start ? '0 : sum_r;
      cnt_nxt  = start ? '0 : cnt_r;
      hold_nxt = hold_cur;
      if (cnt_nxt < aad_pkg::CNT_W'(aad_pkg::MAX_CHANNEL_SAMPLES)) begin
        sum_nxt = sum_nxt + aad_pkg::SUM_W'(sample);
        cnt_nxt = cnt_nxt + 1'b1;
      end
      if (tot_r.samples != '1) tot_nxt.samples = tot_r.samples + 1'b1;
      if (mag_cur >= cfg.clip_level && tot_r.clips != '1) tot_nxt.clips = tot_r.clips + 1'b1;
      if (mag_cur < cfg.silence_level) begin
        run_nxt = (run_cur != '1) ? run_cur + 1'b1 : run_cur;
      end else begin
        run_nxt = '0;
      end
      if (run_nxt == cfg.dropout_length) begin
        run_nxt = '0;
        if (tot_r.dropouts != '1) tot_nxt.dropouts = tot_r.dropouts + 1'b1;
      end
      if (have_cur && hold_cur == '0 && step_mag >= {1'b0, cfg.click_step}) begin
        if (tot_r.clicks != '1) tot_nxt.clicks = tot_r.clicks + 1'b1;
        hold_nxt = cfg.click_hold;
      end
      if (hold_nxt != '0) hold_nxt = hold_nxt - 1'b1;
      if (have_cur && top > tot_r.peak) tot_nxt.peak = top;
      prev_nxt = sample;
      have_nxt = 1'b1;
      open_nxt = !last;
    end else if (clr_buf) begin
      tot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      have_r <= 1'b0;
      open_r <= 1'b0;
      hold_r <= '0;
      run_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      tot_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      have_r <= have_nxt;
      open_r <= open_nxt;
      hold_r <= hold_nxt;
      run_r  <= run_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      tot_r  <= tot_nxt;
    end
  end

  assign tot      = tot_r;
  assign chan_sum = sum_r;
  assign chan_cnt = cnt_r;

endmodule

@@ sv/aad_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the channel mean.
module aad_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [aad_pkg::SUM_W-1:0]   dividend,
  input  logic [aad_pkg::CNT_W-1:0]   divisor,
  output logic                        busy,
  output logic [aad_pkg::MAG_W-1:0]   quotient
);

  localparam int DW  = aad_pkg::SUM_W;
  localparam int VW  = aad_pkg::CNT_W;
  localparam int STW = $clog2(DW + 1);

  logic [DW-1:0]  q_r, q_nxt;
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [VW-1:0]  dvs_r, dvs_nxt;
  logic [STW-1:0] left_r, left_nxt;
  logic [VW:0]    shifted, trial;

  assign shifted = {rem_r, q_r[DW-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    left_nxt = left_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      left_nxt = STW'(DW);
    end else if (left_r != '0) begin
      left_nxt = left_r - 1'b1;
      if (!trial[VW]) begin
        rem_nxt = trial[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[VW-1:0];
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = (left_r != '0);
  assign quotient = q_r[aad_pkg::MAG_W-1:0];

endmodule

@@ dv/audio_artifact_detector_test.sv @@
// Testbench for audio_artifact_detector: directed and random sample streams, result scoreboard.
`timescale 1ns / 1ps
module audio_artifact_detector_test;
  import aad_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int QUIET_RUN_MAX = 'hFFFF;
  localparam longint FULL_POS = 8388607;
  localparam longint FULL_NEG = -8388608;
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 3'd7;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;
  typedef enum int {SIG_NOISE, SIG_QUIET, SIG_RAILS, SIG_STEPS, SIG_NEAR_CLIP} sig_style_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic first;
    logic last;
    logic buf_end;
  } sample_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] abs_mean;
    logic [TOT_W-1:0] clips;
    logic [TOT_W-1:0] samples;
    logic [TOT_W-1:0] clicks;
    logic [TOT_W-1:0] drops;
    logic [MAG_W-1:0] peak;
    logic clip_flag;
    logic buf_end;
  } chan_report_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [SAMPLE_BITS-1:0] in_tdata = '0;  // [23:0] sample
  logic [1:0] in_tuser = '0;              // [0] channel_first, [1] buffer_last
  logic in_tlast = 1'b0;                  // channel_last
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // mean, clips, samples, clicks, dropouts, peak
  logic out_tuser;                        // clipping_flag
  logic out_tlast;                        // final_channel
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // detector state as the block should hold it
  logic [LVL_W-1:0] clip_lvl = CLIP_LEVEL_RST;
  logic [LVL_W-1:0] step_lvl = CLICK_STEP_RST;
  logic [LVL_W-1:0] quiet_lvl = SILENCE_LEVEL_RST;
  logic [LEN_W-1:0] hold_len = CLICK_HOLD_RST;
  logic [LEN_W-1:0] drop_len = DROPOUT_LENGTH_RST;
  longint prev_s = 0;
  bit have_prev = 1'b0;
  bit chan_open = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned quiet_run = 0;
  int unsigned chan_n = 0;
  longint chan_sum = 0;
  logic [TOT_W-1:0] n_clips = '0;
  logic [TOT_W-1:0] n_samples = '0;
  logic [TOT_W-1:0] n_clicks = '0;
  logic [TOT_W-1:0] n_drops = '0;
  longint peak_mag = 0;

  chan_report_t reports_due[$];
  sample_item_t pending[$];
  sample_item_t cur;
  int pushed = 0;
  int taken = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_go = 1'b0;
  logic hold_off = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;
  bit rx_toggle = 1'b0;
  chan_report_t seen;
  chan_report_t want;

  audio_artifact_detector DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [TOT_W-1:0] bump(input logic [TOT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic log_mismatch(input string what, input longint got, input longint exp_v);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, exp_v);
    errors++;
  endtask

  task automatic analyze_sample(input sample_item_t it);
    longint s;
    longint m;
    longint top;
    chan_report_t r;
    s = longint'($signed(it.sample));
    m = magnitude(s);
    if (it.first || !chan_open) begin
      hold_cnt = 0;
      quiet_run = 0;
      chan_sum = 0;
      chan_n = 0;
      have_prev = 1'b0;
      chan_open = 1'b1;
    end
    if (chan_n < MAX_CHANNEL_SAMPLES) begin
      chan_sum += s;
      chan_n++;
    end
    n_samples = bump(n_samples);
    if (m >= clip_lvl) n_clips = bump(n_clips);
    if (m < quiet_lvl) begin
      if (quiet_run < QUIET_RUN_MAX) quiet_run++;
    end else begin
      quiet_run = 0;
    end
    if (quiet_run == drop_len) begin
      n_drops = bump(n_drops);
      quiet_run = 0;
    end
    if (have_prev && hold_cnt == 0 && magnitude(s - prev_s) >= step_lvl) begin
      n_clicks = bump(n_clicks);
      hold_cnt = hold_len;
    end
    if (hold_cnt > 0) hold_cnt--;
    if (have_prev) begin
      top = (magnitude(prev_s) > m) ? magnitude(prev_s) : m;
      if (top > peak_mag) peak_mag = top;
    end
    prev_s = s;
    have_prev = 1'b1;
    if (it.last) begin
      r.abs_mean = (chan_n == 0) ? '0 : MAG_W'((magnitude(chan_sum) + chan_n / 2) / chan_n);
      r.clips = n_clips;
      r.samples = n_samples;
      r.clicks = n_clicks;
      r.drops = n_drops;
      r.peak = MAG_W'(peak_mag);
      r.clip_flag = (longint'(n_clips) * 10000 > longint'(n_samples));
      r.buf_end = it.buf_end;
      reports_due.push_back(r);
      chan_open = 1'b0;
      if (it.buf_end) begin
        n_clips = '0;
        n_samples = '0;
        n_clicks = '0;
        n_drops = '0;
        peak_mag = 0;
      end
    end
  endtask

  task automatic push_item(input logic [SAMPLE_BITS-1:0] s, input logic f, input logic l,
                           input logic b);
    pending.push_back('{sample: s, first: f, last: l, buf_end: b});
    pushed++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (a)
      CFG_CLIP_LEVEL: clip_lvl = d;
      CFG_CLICK_STEP: step_lvl = d;
      CFG_CLICK_HOLD: hold_len = d[LEN_W-1:0];
      CFG_SILENCE_LEVEL: quiet_lvl = d;
      CFG_DROPOUT_LENGTH: drop_len = d[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic shuffle_thresholds();
    write_reg(CFG_CLIP_LEVEL, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                              : CFG_DATA_W'($urandom_range(8000000, 8388608)));
    write_reg(CFG_CLICK_STEP, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                              : CFG_DATA_W'($urandom_range(1000, 6000000)));
    write_reg(CFG_CLICK_HOLD, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                              : CFG_DATA_W'($urandom_range(0, 24)));
    write_reg(CFG_SILENCE_LEVEL, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                                 : CFG_DATA_W'($urandom_range(0, 4000)));
    write_reg(CFG_DROPOUT_LENGTH, ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom())
                                  : CFG_DATA_W'($urandom_range(64, 96)));
  endtask

  function automatic longint pick_value(input sig_style_t st, input longint prev);
    logic [31:0] r;
    longint v;
    longint k;
    longint lim;
    r = $urandom();
    case (st)
      SIG_QUIET: begin
        lim = (quiet_lvl > 24'h800000) ? 8388608 : longint'(quiet_lvl);
        if (lim == 0 || $urandom_range(0, 99) == 0) begin
          v = longint'($signed(r[23:0]));
        end else begin
          k = $urandom_range(0, lim - 1);
          v = r[31] ? -k : k;
        end
      end
      SIG_RAILS: begin
        k = $urandom_range(0, 3);
        case (r[2:0])
          3'd0: v = FULL_NEG;
          3'd1: v = FULL_POS;
          3'd2: v = 0;
          3'd3: v = -1;
          3'd4: v = 1;
          default: v = r[31] ? FULL_NEG + k : FULL_POS - k;
        endcase
      end
      SIG_STEPS: begin
        if (r[3:0] == 4'd0) begin
          k = $urandom_range(0, 2);
          k = longint'(step_lvl) + k - 1;
          v = r[31] ? prev - k : prev + k;
        end else begin
          k = $urandom_range(0, 2000);
          v = prev + k - 1000;
        end
      end
      SIG_NEAR_CLIP: begin
        k = $urandom_range(0, 4);
        v = longint'(clip_lvl) + k - 2;
        if (v > 8388608) v = 8388608;
        if (v < 0) v = 0;
        if (r[31]) v = -v;
      end
      default: v = longint'($signed(r[23:0]));
    endcase
    if (v > FULL_POS) v = FULL_POS;
    if (v < FULL_NEG) v = FULL_NEG;
    return v;
  endfunction

  // buffers of whole channels, with some stray first and buffer_last flags mixed in
  task automatic make_traffic(input int n_items, input int max_len);
    int start;
    int n_chan;
    int c;
    int i;
    int len;
    sig_style_t st;
    longint v;
    start = pushed;
    while (pushed - start < n_items) begin
      n_chan = $urandom_range(1, 4);
      for (c = 0; c < n_chan; c++) begin
        st = sig_style_t'($urandom_range(0, 4));
        len = $urandom_range(1, max_len);
        if (max_len > 8 && $urandom_range(0, 7) == 0) begin
          st = SIG_QUIET;
          len = $urandom_range(64, 150);
        end
        v = 0;
        for (i = 0; i < len; i++) begin
          v = pick_value(st, v);
          push_item(v[SAMPLE_BITS-1:0],
                    (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 39) == 0),
                    i == len - 1,
                    (i == len - 1) ? (c == n_chan - 1) : ($urandom_range(0, 29) == 0));
        end
      end
    end
  endtask

  task automatic drain();
    while (taken != pushed || reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        analyze_sample(cur);
        taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        cur = pending.pop_front();
        in_tdata <= cur.sample;
        in_tuser <= {cur.buf_end, cur.first};
        in_tlast <= cur.last;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: ready pattern (open, coin-flip, sparse or toggling) picked at random and held for a random run
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 128);
    end else begin
      rx_left--;
    end
    rx_toggle = !rx_toggle;
    case (rx_mode)
      RX_OPEN: out_tready <= !hold_off;
      RX_COIN: out_tready <= !hold_off && ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_tready <= !hold_off && ($urandom_range(0, 7) == 0);
      default: out_tready <= !hold_off && rx_toggle;
    endcase
  end

  // long receiver hold-off so the result register fills and the input backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.abs_mean = out_tdata[23:0];
      seen.clips = out_tdata[55:24];
      seen.samples = out_tdata[87:56];
      seen.clicks = out_tdata[119:88];
      seen.drops = out_tdata[151:120];
      seen.peak = out_tdata[175:152];
      seen.clip_flag = out_tuser;
      seen.buf_end = out_tlast;
      if (reports_due.size() == 0) begin
        log_mismatch("result with none due, mean", seen.abs_mean, 0);
      end else begin
        want = reports_due.pop_front();
        if (seen.abs_mean !== want.abs_mean)
          log_mismatch("channel_abs_mean", seen.abs_mean, want.abs_mean);
        if (seen.clips !== want.clips) log_mismatch("clip_total", seen.clips, want.clips);
        if (seen.samples !== want.samples)
          log_mismatch("sample_total", seen.samples, want.samples);
        if (seen.clicks !== want.clicks) log_mismatch("click_total", seen.clicks, want.clicks);
        if (seen.drops !== want.drops) log_mismatch("dropout_total", seen.drops, want.drops);
        if (seen.peak !== want.peak) log_mismatch("peak_magnitude", seen.peak, want.peak);
        if (seen.clip_flag !== want.clip_flag)
          log_mismatch("clipping_flag", seen.clip_flag, want.clip_flag);
        if (seen.buf_end !== want.buf_end)
          log_mismatch("final_channel", seen.buf_end, want.buf_end);
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default thresholds
    push_item(24'd0, 1'b0, 1'b0, 1'b0);        // no channel open yet
    push_item(24'h7FFFFF, 1'b0, 1'b0, 1'b0);
    push_item(24'h800000, 1'b0, 1'b0, 1'b0);   // full-scale step
    push_item(24'h7FFFFF, 1'b0, 1'b0, 1'b0);   // inside hold
    push_item(24'd5, 1'b0, 1'b0, 1'b1);        // buffer_last alone is ignored
    push_item(24'(-3), 1'b0, 1'b1, 1'b0);
    push_item(24'h800000, 1'b1, 1'b1, 1'b0);   // one-sample channel
    push_item(24'd100, 1'b0, 1'b0, 1'b0);
    push_item(24'(-100), 1'b1, 1'b0, 1'b0);    // restart mid-channel
    push_item(24'd83, 1'b0, 1'b0, 1'b0);
    push_item(24'd84, 1'b0, 1'b0, 1'b0);
    push_item(24'(-84), 1'b0, 1'b0, 1'b0);
    push_item(24'd8384414, 1'b0, 1'b0, 1'b0);
    push_item(24'(-8384413), 1'b0, 1'b0, 1'b0);
    push_item(24'(-8384414), 1'b0, 1'b1, 1'b0);
    push_item(24'd1, 1'b1, 1'b0, 1'b0);        // mean 1.5 rounds up
    push_item(24'd2, 1'b0, 1'b1, 1'b0);
    push_item(24'd4194304, 1'b1, 1'b0, 1'b0);
    push_item(24'd0, 1'b0, 1'b0, 1'b0);        // step exactly at threshold
    push_item(24'd1, 1'b0, 1'b0, 1'b0);
    push_item(24'(-1), 1'b0, 1'b1, 1'b1);
    push_item(24'd0, 1'b1, 1'b1, 1'b1);
    drain();

    write_reg(CFG_CLIP_LEVEL, '0);
    write_reg(CFG_CLICK_STEP, '0);
    write_reg(CFG_CLICK_HOLD, '0);
    write_reg(CFG_SILENCE_LEVEL, 24'h800000);
    write_reg(CFG_DROPOUT_LENGTH, 24'd64);
    make_traffic(50, 12);
    drain();

    write_reg(CFG_CLIP_LEVEL, 24'h800000);
    write_reg(CFG_CLICK_STEP, 24'hFFFFFF);
    write_reg(CFG_CLICK_HOLD, 24'h00FFFF);
    write_reg(CFG_SILENCE_LEVEL, '0);
    write_reg(CFG_DROPOUT_LENGTH, 24'd32768);
    write_reg(CFG_NO_REG, CFG_DATA_W'($urandom()));
    make_traffic(30, 12);
    drain();

    repeat (4) begin
      shuffle_thresholds();
      make_traffic(35, 12);
      drain();
    end

    shuffle_thresholds();
    hold_go = 1'b1;
    make_traffic(60, 2);
    drain();

    // zero dropout length: every sample that is not near zero meets it
    write_reg(CFG_SILENCE_LEVEL, SILENCE_LEVEL_RST);
    write_reg(CFG_DROPOUT_LENGTH, '0);
    push_item(24'd40, 1'b1, 1'b0, 1'b0);
    push_item(24'd500, 1'b0, 1'b0, 1'b0);
    push_item(24'(-2), 1'b0, 1'b1, 1'b0);
    drain();
    write_reg(CFG_DROPOUT_LENGTH, 24'h00FFFF);
    push_item(24'd3, 1'b0, 1'b0, 1'b0);
    push_item(24'(-7), 1'b0, 1'b0, 1'b0);
    push_item(24'h123456, 1'b0, 1'b0, 1'b0);
    push_item(24'd16, 1'b0, 1'b1, 1'b1);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/aad_pkg.sv
sv/aad_sample_unit.sv
sv/aad_divider.sv
sv/audio_artifact_detector.sv
dv/audio_artifact_detector_test.sv
